[rtl/core/tscs_pkg.sv]
// Package for the timed servo cover sequencer: phase codes, action codes,
// register indexes, controller state types and the ramp request bundle.
// No dependencies.
package tscs_pkg;

    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned DUR_W     = 16;
    localparam int unsigned ANGLE_W   = 8;
    localparam int unsigned PROD_W    = DUR_W + ANGLE_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    typedef enum logic [2:0] {
        PH_CLOSED      = 3'd0,
        PH_OPENING     = 3'd1,
        PH_HOLD_OPEN   = 3'd2,
        PH_OPENED      = 3'd3,
        PH_CLOSING     = 3'd4,
        PH_HOLD_CLOSED = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_SPARE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_OPENING_MS       = 3'd0,
        REG_HOLD_OPEN_MS     = 3'd1,
        REG_CLOSING_MS       = 3'd2,
        REG_HOLD_CLOSED_MS   = 3'd3,
        REG_FIRST_SERVO_MIN  = 3'd4,
        REG_FIRST_SERVO_MAX  = 3'd5,
        REG_SECOND_SERVO_MIN = 3'd6,
        REG_SECOND_SERVO_MAX = 3'd7
    } reg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RAMP = 1'b1
    } ctl_state_t;

    typedef enum logic [1:0] {
        RS_IDLE = 2'd0,
        RS_MUL  = 2'd1,
        RS_DIV  = 2'd2,
        RS_DONE = 2'd3
    } ramp_state_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] lo;
        logic [ANGLE_W-1:0] hi;
        logic [DUR_W-1:0]   t;
        logic [DUR_W-1:0]   d;
    } ramp_req_t;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

endpackage

[rtl/core/tscs_ramp.sv]
// Bit-serial ramp angle unit: floor(lo + t*(hi-lo)/d) with 0 <= t <= d.
// Shift-add multiply, one diff bit per cycle, then restoring divide, one
// quotient bit per cycle. Depends on tscs_pkg.
module tscs_ramp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  tscs_pkg::ramp_req_t          req,
    output logic                         done,
    output logic [tscs_pkg::ANGLE_W-1:0] angle
);

    tscs_pkg::ramp_state_t rs_state_reg, rs_state_next;
    logic [2:0]                          cnt_reg, cnt_next;
    logic [tscs_pkg::ANGLE_W-1:0]        diff_reg, diff_next;
    logic [tscs_pkg::ANGLE_W-1:0]        lo_reg, lo_next;
    logic                                down_reg, down_next;
    logic [tscs_pkg::DUR_W-1:0]          t_reg, t_next;
    logic [tscs_pkg::DUR_W-1:0]          d_reg, d_next;
    logic [tscs_pkg::PROD_W-1:0]         acc_reg, acc_next;
    logic [tscs_pkg::DUR_W-1:0]          rem_reg, rem_next;

    logic [tscs_pkg::PROD_W-1:0]         acc_mul;
    logic [tscs_pkg::DUR_W:0]            trial;
    logic [tscs_pkg::DUR_W:0]            trial_sub;
    logic                                q_bit;
    logic [tscs_pkg::ANGLE_W-1:0]        round_up;

    // One multiply step: shift and add t when the diff's top bit is set.
    assign acc_mul = {acc_reg[tscs_pkg::PROD_W-2:0], 1'b0}
                   + (diff_reg[tscs_pkg::ANGLE_W-1]
                      ? {{tscs_pkg::ANGLE_W{1'b0}}, t_reg}
                      : {tscs_pkg::PROD_W{1'b0}});

    // One divide step: bring down the next numerator bit and try d.
    assign trial     = {rem_reg, acc_reg[tscs_pkg::ANGLE_W-1]};
    assign trial_sub = trial - {1'b0, d_reg};
    assign q_bit     = (trial >= {1'b0, d_reg});

    always_comb begin
        rs_state_next = rs_state_reg;
        cnt_next      = cnt_reg;
        diff_next     = diff_reg;
        lo_next       = lo_reg;
        down_next     = down_reg;
        t_next        = t_reg;
        d_next        = d_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        case (rs_state_reg)
            tscs_pkg::RS_IDLE: begin
                if (start) begin
                    lo_next   = req.lo;
                    down_next = (req.hi < req.lo);
                    diff_next = (req.hi < req.lo) ? (req.lo - req.hi) : (req.hi - req.lo);
                    t_next    = req.t;
                    d_next    = req.d;
                    acc_next  = '0;
                    cnt_next  = '0;
                    rs_state_next = tscs_pkg::RS_MUL;
                end
            end
            tscs_pkg::RS_MUL: begin
                acc_next  = acc_mul;
                diff_next = {diff_reg[tscs_pkg::ANGLE_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    // Upper part of the product is below d, since t <= d.
                    rem_next = acc_mul[tscs_pkg::PROD_W-1:tscs_pkg::ANGLE_W];
                    cnt_next = '0;
                    rs_state_next = tscs_pkg::RS_DIV;
                end
            end
            tscs_pkg::RS_DIV: begin
                rem_next = q_bit ? trial_sub[tscs_pkg::DUR_W-1:0]
                                 : trial[tscs_pkg::DUR_W-1:0];
                acc_next[tscs_pkg::ANGLE_W-1:0] =
                    {acc_reg[tscs_pkg::ANGLE_W-2:0], q_bit};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    rs_state_next = tscs_pkg::RS_DONE;
                end
            end
            tscs_pkg::RS_DONE: begin
                rs_state_next = tscs_pkg::RS_IDLE;
            end
            default: begin
                rs_state_next = tscs_pkg::RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_state_reg <= tscs_pkg::RS_IDLE;
            cnt_reg      <= '0;
        end else begin
            rs_state_reg <= rs_state_next;
            cnt_reg      <= cnt_next;
        end
        diff_reg <= diff_next;
        lo_reg   <= lo_next;
        down_reg <= down_next;
        t_reg    <= t_next;
        d_reg    <= d_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
    end

    // Downward ramps take the ceiling of the magnitude so the angle floors.
    assign round_up = acc_reg[tscs_pkg::ANGLE_W-1:0]
                    + {{(tscs_pkg::ANGLE_W-1){1'b0}}, (rem_reg != '0)};
    assign done  = (rs_state_reg == tscs_pkg::RS_DONE);
    assign angle = down_reg ? (lo_reg - round_up)
                            : (lo_reg + acc_reg[tscs_pkg::ANGLE_W-1:0]);

endmodule

[rtl/core/timed_servo_cover_sequencer.sv]
// Top level of the timed servo cover sequencer: phase controller, elapsed
// timer, configuration registers and output register.
// Depends on tscs_pkg and tscs_ramp.
//
// The block steps a cover through six phases (closed, opening, holding open,
// opened, closing, holding closed) and produces one result word for every
// input word. A tick word adds ms_step to the elapsed time, saturating at
// 131071; an open or close command restarts the elapsed time, sets or clears
// the LED and enters a ramp. During a ramp each servo angle is
// floor(min + t*(max-min)/d), with t the elapsed time when opening and
// d minus elapsed when closing; a duration register of zero acts as one.
// Hold phases write the end angles and detach the servos when they expire.
// Timing: a word that needs no ramp angle is accepted and its result is
// registered at the same edge, so such words flow at one per cycle while
// the sink takes each result. A word that lands inside a ramp gets its
// result once two bit-serial ramp units, one per servo, have run side by
// side through 8 shift-add multiply steps, 8 restoring divide steps and a
// finish state. A new word is taken whenever the controller is idle and
// the result register is empty or being emptied in the same cycle.
// Configuration writes are accepted in every cycle (cfg_ready is tied high)
// and should only be issued while the block holds no word in flight.
module timed_servo_cover_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [7:0]                     s_ms_step,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_first_angle,
    output logic [7:0]                     m_second_angle,
    output logic                           m_angle_valid,
    output logic                           m_drive_enabled,
    output logic [2:0]                     m_phase_now,
    output logic                           m_led_on,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tscs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tscs_pkg::CFG_DAT_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] opening_ms_reg, opening_ms_next;
    logic [15:0] hold_open_ms_reg, hold_open_ms_next;
    logic [15:0] closing_ms_reg, closing_ms_next;
    logic [15:0] hold_closed_ms_reg, hold_closed_ms_next;
    logic [7:0]  first_min_reg, first_min_next;
    logic [7:0]  first_max_reg, first_max_next;
    logic [7:0]  second_min_reg, second_min_next;
    logic [7:0]  second_max_reg, second_max_next;

    logic cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        opening_ms_next     = opening_ms_reg;
        hold_open_ms_next   = hold_open_ms_reg;
        closing_ms_next     = closing_ms_reg;
        hold_closed_ms_next = hold_closed_ms_reg;
        first_min_next      = first_min_reg;
        first_max_next      = first_max_reg;
        second_min_next     = second_min_reg;
        second_max_next     = second_max_reg;
        if (cfg_write) begin
            case (tscs_pkg::reg_index_t'(cfg_index))
                tscs_pkg::REG_OPENING_MS:       opening_ms_next     = cfg_data;
                tscs_pkg::REG_HOLD_OPEN_MS:     hold_open_ms_next   = cfg_data;
                tscs_pkg::REG_CLOSING_MS:       closing_ms_next     = cfg_data;
                tscs_pkg::REG_HOLD_CLOSED_MS:   hold_closed_ms_next = cfg_data;
                tscs_pkg::REG_FIRST_SERVO_MIN:  first_min_next      = cfg_data[7:0];
                tscs_pkg::REG_FIRST_SERVO_MAX:  first_max_next      = cfg_data[7:0];
                tscs_pkg::REG_SECOND_SERVO_MIN: second_min_next     = cfg_data[7:0];
                tscs_pkg::REG_SECOND_SERVO_MAX: second_max_next     = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opening_ms_reg     <= 16'd1000;
            hold_open_ms_reg   <= 16'd500;
            closing_ms_reg     <= 16'd1000;
            hold_closed_ms_reg <= 16'd500;
            first_min_reg      <= 8'd0;
            first_max_reg      <= 8'd180;
            second_min_reg     <= 8'd0;
            second_max_reg     <= 8'd180;
        end else begin
            opening_ms_reg     <= opening_ms_next;
            hold_open_ms_reg   <= hold_open_ms_next;
            closing_ms_reg     <= closing_ms_next;
            hold_closed_ms_reg <= hold_closed_ms_next;
            first_min_reg      <= first_min_next;
            first_max_reg      <= first_max_next;
            second_min_reg     <= second_min_next;
            second_max_reg     <= second_max_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and controller
    // ------------------------------------------------------------------
    tscs_pkg::phase_t                phase_reg, phase_next;
    logic [tscs_pkg::ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic                            attached_reg, attached_next;
    logic                            led_reg, led_next;
    tscs_pkg::ctl_state_t            ctl_state_reg, ctl_state_next;

    logic                            in_take;
    logic                            ramp_start;
    logic                            ramp_done_a, ramp_done_b;
    logic [7:0]                      ramp_angle_a, ramp_angle_b;
    tscs_pkg::ramp_req_t             req_a, req_b;

    // Evaluation of the accepted word, all combinational from the state.
    tscs_pkg::action_t               act;
    tscs_pkg::phase_t                ph_cmd;
    logic [tscs_pkg::ELAPSED_W:0]    el_sum;
    logic [tscs_pkg::ELAPSED_W-1:0]  el_cur;
    logic                            led_cmd;
    logic [15:0]                     dur_raw;
    logic [15:0]                     dur;
    logic                            el_le, el_ge;
    logic [15:0]                     ramp_t;
    logic                            need_ramp;
    logic                            word_valid;
    logic [7:0]                      hold_a, hold_b;

    assign act    = tscs_pkg::action_t'(s_action);
    assign el_sum = {1'b0, elapsed_reg} + {{(tscs_pkg::ELAPSED_W-7){1'b0}}, s_ms_step};

    // Apply the command or advance the timer first.
    always_comb begin
        ph_cmd  = phase_reg;
        led_cmd = led_reg;
        el_cur  = el_sum[tscs_pkg::ELAPSED_W] ? tscs_pkg::ELAPSED_MAX
                                              : el_sum[tscs_pkg::ELAPSED_W-1:0];
        case (act)
            tscs_pkg::ACT_OPEN: begin
                ph_cmd  = tscs_pkg::PH_OPENING;
                led_cmd = 1'b1;
                el_cur  = '0;
            end
            tscs_pkg::ACT_CLOSE: begin
                ph_cmd  = tscs_pkg::PH_CLOSING;
                led_cmd = 1'b0;
                el_cur  = '0;
            end
            default: begin
            end
        endcase
    end

    // Duration of the phase now in force; zero acts as one.
    always_comb begin
        case (ph_cmd)
            tscs_pkg::PH_OPENING:     dur_raw = opening_ms_reg;
            tscs_pkg::PH_CLOSING:     dur_raw = closing_ms_reg;
            tscs_pkg::PH_HOLD_OPEN:   dur_raw = hold_open_ms_reg;
            tscs_pkg::PH_HOLD_CLOSED: dur_raw = hold_closed_ms_reg;
            default:                  dur_raw = 16'd1;
        endcase
    end

    assign dur    = (dur_raw == 16'd0) ? 16'd1 : dur_raw;
    assign el_le  = (el_cur <= {1'b0, dur});
    assign el_ge  = (el_cur >= {1'b0, dur});
    // Only used when el_le holds, so the difference fits in 16 bits.
    assign ramp_t = (ph_cmd == tscs_pkg::PH_OPENING) ? el_cur[15:0]
                                                     : (dur - el_cur[15:0]);

    // Phase rules: next phase, elapsed, attach and which angles to write.
    always_comb begin
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        attached_next = attached_reg;
        led_next      = led_reg;
        need_ramp     = 1'b0;
        word_valid    = 1'b0;
        hold_a        = 8'd0;
        hold_b        = 8'd0;
        if (in_take) begin
            phase_next   = ph_cmd;
            elapsed_next = el_cur;
            led_next     = led_cmd;
            case (ph_cmd)
                tscs_pkg::PH_CLOSED,
                tscs_pkg::PH_OPENED: begin
                    attached_next = 1'b0;
                end
                tscs_pkg::PH_OPENING,
                tscs_pkg::PH_CLOSING: begin
                    if (el_le) begin
                        attached_next = 1'b1;
                        need_ramp     = 1'b1;
                        word_valid    = 1'b1;
                    end
                    if (el_ge) begin
                        phase_next   = (ph_cmd == tscs_pkg::PH_OPENING)
                                     ? tscs_pkg::PH_HOLD_OPEN : tscs_pkg::PH_HOLD_CLOSED;
                        elapsed_next = '0;
                    end
                end
                tscs_pkg::PH_HOLD_OPEN,
                tscs_pkg::PH_HOLD_CLOSED: begin
                    if (el_le) begin
                        attached_next = 1'b1;
                        word_valid    = 1'b1;
                        hold_a = (ph_cmd == tscs_pkg::PH_HOLD_OPEN) ? first_max_reg
                                                                    : first_min_reg;
                        hold_b = (ph_cmd == tscs_pkg::PH_HOLD_OPEN) ? second_max_reg
                                                                    : second_min_reg;
                    end
                    if (el_ge) begin
                        attached_next = 1'b0;
                        phase_next    = (ph_cmd == tscs_pkg::PH_HOLD_OPEN)
                                      ? tscs_pkg::PH_OPENED : tscs_pkg::PH_CLOSED;
                        elapsed_next  = '0;
                    end
                end
                default: begin
                    // Unused phase codes: leave the attach state as it is, write nothing.
                end
            endcase
        end
    end

    // Controller next state.
    always_comb begin
        ctl_state_next = ctl_state_reg;
        case (ctl_state_reg)
            tscs_pkg::ST_IDLE: begin
                if (in_take && need_ramp) begin
                    ctl_state_next = tscs_pkg::ST_RAMP;
                end
            end
            tscs_pkg::ST_RAMP: begin
                if (ramp_done_a) begin
                    ctl_state_next = tscs_pkg::ST_IDLE;
                end
            end
            default: begin
                ctl_state_next = tscs_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs: take a word only when idle and the result slot
    // is free by the end of this cycle.
    always_comb begin
        s_ready    = 1'b0;
        ramp_start = 1'b0;
        case (ctl_state_reg)
            tscs_pkg::ST_IDLE: begin
                s_ready    = !m_valid || m_ready;
                ramp_start = in_take && need_ramp;
            end
            tscs_pkg::ST_RAMP: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= tscs_pkg::PH_CLOSED;
            elapsed_reg   <= '0;
            attached_reg  <= 1'b1;
            led_reg       <= 1'b0;
            ctl_state_reg <= tscs_pkg::ST_IDLE;
        end else begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            attached_reg  <= attached_next;
            led_reg       <= led_next;
            ctl_state_reg <= ctl_state_next;
        end
    end

    // ------------------------------------------------------------------
    // Ramp units, one per servo, started together
    // ------------------------------------------------------------------
    assign req_a = '{lo: first_min_reg,  hi: first_max_reg,  t: ramp_t, d: dur};
    assign req_b = '{lo: second_min_reg, hi: second_max_reg, t: ramp_t, d: dur};

    tscs_ramp u_ramp_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ramp_start),
        .req     (req_a),
        .done    (ramp_done_a),
        .angle   (ramp_angle_a)
    );

    tscs_ramp u_ramp_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ramp_start),
        .req     (req_b),
        .done    (ramp_done_b),
        .angle   (ramp_angle_b)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic       m_valid_reg, m_valid_next;
    logic [7:0] first_angle_reg, first_angle_next;
    logic [7:0] second_angle_reg, second_angle_next;
    logic       angle_valid_reg, angle_valid_next;
    logic       drive_reg, drive_next;
    logic [2:0] phase_out_reg, phase_out_next;
    logic       led_out_reg, led_out_next;

    always_comb begin
        m_valid_next      = m_valid_reg;
        first_angle_next  = first_angle_reg;
        second_angle_next = second_angle_reg;
        angle_valid_next  = angle_valid_reg;
        drive_next        = drive_reg;
        phase_out_next    = phase_out_reg;
        led_out_next      = led_out_reg;
        // Drop the word once the sink takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        // Capture status on acceptance; a ramp word fills its angles later.
        if (in_take) begin
            first_angle_next  = hold_a;
            second_angle_next = hold_b;
            angle_valid_next  = word_valid;
            drive_next        = attached_next;
            phase_out_next    = phase_next;
            led_out_next      = led_next;
            if (!need_ramp) begin
                m_valid_next = 1'b1;
            end
        end
        if (ctl_state_reg == tscs_pkg::ST_RAMP && ramp_done_a) begin
            first_angle_next  = ramp_angle_a;
            second_angle_next = ramp_angle_b;
            m_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        first_angle_reg  <= first_angle_next;
        second_angle_reg <= second_angle_next;
        angle_valid_reg  <= angle_valid_next;
        drive_reg        <= drive_next;
        phase_out_reg    <= phase_out_next;
        led_out_reg      <= led_out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_first_angle   = first_angle_reg;
    assign m_second_angle  = second_angle_reg;
    assign m_angle_valid   = angle_valid_reg;
    assign m_drive_enabled = drive_reg;
    assign m_phase_now     = phase_out_reg;
    assign m_led_on        = led_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Both ramp units start together and must finish together.
    a_ramp_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        ramp_done_a == ramp_done_b)
        else $error("ramp units out of step");

    // A ramp result only arrives while the controller waits for it.
    a_done_in_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        ramp_done_a |-> ctl_state_reg == tscs_pkg::ST_RAMP)
        else $error("ramp finished outside ramp state");

    // The result slot stays empty while a ramp word is being computed.
    a_slot_free_in_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_state_reg == tscs_pkg::ST_RAMP |-> !m_valid_reg)
        else $error("result pending during ramp");

    // Unwritten angles read as zero.
    a_angles_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !angle_valid_reg) |->
            (first_angle_reg == 8'd0 && second_angle_reg == 8'd0))
        else $error("angles nonzero without write");

endmodule
